[design/pce_pkg.sv]
// Shared constants, codes and types of the correlation engine.
// Used by the interfaces, the controller, the datapath and the top level.
package pce_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int MAX_SAMPLES = 4096;
    localparam int FRAC_BITS   = 16;
    localparam int RES_W       = 48;
    localparam int STATUS_W    = 2;
    localparam int MODE_W      = 2;

    localparam int CNT_W   = $clog2(MAX_SAMPLES + 1);
    localparam int SUM_W   = SAMPLE_BITS + CNT_W;
    localparam int SQ_W    = 2 * SAMPLE_BITS + CNT_W - 1;
    localparam int XY_W    = SQ_W + 1;
    localparam int CEN_W   = CNT_W + XY_W + 1;
    localparam int MUL_W   = CEN_W;
    localparam int PRD_W   = 2 * MUL_W;
    localparam int NN_W    = 2 * CNT_W;
    localparam int DD_W    = CEN_W + FRAC_BITS + 2;
    localparam int DS_W    = NN_W + 1;
    localparam int SQ_STEPS = FRAC_BITS + 1;
    localparam int SQC_W   = $clog2(SQ_STEPS + 1);
    localparam int E_W     = PRD_W + 2 * FRAC_BITS + 5;

    localparam logic [MODE_W-1:0] MODE_VAR  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_COV  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CORR = 2'd2;

    typedef enum logic [STATUS_W-1:0] {
        ST_VALID    = 2'd0,
        ST_ZERO_VAR = 2'd1,
        ST_OVERFLOW = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        J_NSXX, J_SXSX, J_NSXY, J_SXSY, J_NSYY, J_SYSY, J_NN, J_VV, J_CC
    } job_t;

    typedef enum logic [3:0] {
        S_IDLE, S_DECIDE, S_MUL, S_MWAIT, S_ZCHK, S_DIV, S_DWAIT,
        S_SQINIT, S_SQ, S_OUT
    } state_t;

    typedef struct packed {
        logic          acc_en;
        logic          clear;
        logic          mul_start;
        job_t          job;
        logic          div_start;
        logic          sq_init;
        logic          sq_step;
        logic          out_load;
        status_t       status;
    } cmd_t;

    typedef struct packed {
        logic ovf;
        logic mul_done;
        logic div_done;
        logic var_zero;
        logic sq_done;
    } sts_t;

endpackage

[design/pce_if.sv]
// Handshake channels of the correlation engine: sample words in, result words out.
// Depends on pce_pkg for field widths.
interface pce_in_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [pce_pkg::SAMPLE_BITS-1:0] sample_x;
    logic signed [pce_pkg::SAMPLE_BITS-1:0] sample_y;
    logic                                  last;

    modport source (output valid, sample_x, sample_y, last, input ready);
    modport sink   (input valid, sample_x, sample_y, last, output ready);
endinterface

interface pce_out_if;
    logic                               valid;
    logic                               ready;
    logic signed [pce_pkg::RES_W-1:0]    result;
    logic [pce_pkg::STATUS_W-1:0]        status;

    modport source (output valid, result, status, input ready);
    modport sink   (input valid, result, status, output ready);
endinterface

[design/pce_mul.sv]
// Shift-add unsigned multiplier, one multiplier bit per cycle.
// Depends on pce_pkg for the operand width.
module pce_mul (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [pce_pkg::MUL_W-1:0]   a,
    input  logic [pce_pkg::MUL_W-1:0]   b,
    output logic                        done,
    output logic [pce_pkg::PRD_W-1:0]   product
);
    localparam int CW = $clog2(pce_pkg::MUL_W + 1);

    logic [pce_pkg::PRD_W-1:0] acc_reg, acc_next;
    logic [pce_pkg::MUL_W-1:0] a_reg;
    logic [CW-1:0]             cnt_reg, cnt_next;
    logic                      done_reg, done_next;
    logic [pce_pkg::MUL_W:0]   part;

    always_comb
    begin
        part      = {1'b0, acc_reg[pce_pkg::PRD_W-1:pce_pkg::MUL_W]}
                  + (acc_reg[0] ? {1'b0, a_reg} : '0);
        acc_next  = {part, acc_reg[pce_pkg::MUL_W-1:1]};
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start)
        begin
            acc_next = {{pce_pkg::MUL_W{1'b0}}, b};
            cnt_next = CW'(pce_pkg::MUL_W);
        end
        else if (cnt_reg != '0)
        begin
            cnt_next  = cnt_reg - 1'b1;
            done_next = (cnt_reg == CW'(1));
        end
        else
        begin
            acc_next = acc_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        if (start)
        begin
            a_reg <= a;
        end
    end

    assign done    = done_reg;
    assign product = acc_reg;
endmodule

[design/pce_div.sv]
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on pce_pkg for dividend and divisor widths.
module pce_div (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [pce_pkg::DD_W-1:0]   dividend,
    input  logic [pce_pkg::DS_W-1:0]   divisor,
    output logic                       done,
    output logic [pce_pkg::DD_W-1:0]   quotient
);
    localparam int CW = $clog2(pce_pkg::DD_W + 1);

    logic [pce_pkg::DD_W-1:0] q_reg, q_next;
    logic [pce_pkg::DS_W:0]   rem_reg, rem_next;
    logic [pce_pkg::DS_W-1:0] d_reg;
    logic [CW-1:0]            cnt_reg, cnt_next;
    logic                     done_reg, done_next;
    logic [pce_pkg::DS_W:0]   shifted;
    logic [pce_pkg::DS_W+1:0] diff;

    always_comb
    begin
        shifted   = {rem_reg[pce_pkg::DS_W-1:0], q_reg[pce_pkg::DD_W-1]};
        diff      = {1'b0, shifted} - {2'b00, d_reg};
        q_next    = q_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start)
        begin
            q_next   = dividend;
            rem_next = '0;
            cnt_next = CW'(pce_pkg::DD_W);
        end
        else if (cnt_reg != '0)
        begin
            cnt_next  = cnt_reg - 1'b1;
            done_next = (cnt_reg == CW'(1));
            if (!diff[pce_pkg::DS_W+1])
            begin
                rem_next = diff[pce_pkg::DS_W:0];
                q_next   = {q_reg[pce_pkg::DD_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted;
                q_next   = {q_reg[pce_pkg::DD_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        rem_reg <= rem_next;
        if (start)
        begin
            d_reg <= divisor;
        end
    end

    assign done     = done_reg;
    assign quotient = q_reg;
endmodule

[design/pce_ctrl.sv]
// Controller: sequences accumulation, the product jobs, divide, root search and output.
// Depends on pce_pkg for state, job, command and status types.
module pce_ctrl (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [pce_pkg::MODE_W-1:0]    mode,
    input  logic                          in_valid,
    input  logic                          in_last,
    output logic                          in_ready,
    output logic                          out_valid,
    input  logic                          out_ready,
    input  pce_pkg::sts_t                 sts,
    output pce_pkg::cmd_t                 cmd
);
    pce_pkg::state_t  state_reg, state_next;
    pce_pkg::job_t    job_reg, job_next;
    pce_pkg::status_t status_reg, status_next;
    logic             out_valid_reg, out_valid_next;
    logic             is_corr;
    logic             accept;
    logic             can_load;

    assign is_corr  = (mode != pce_pkg::MODE_VAR) && (mode != pce_pkg::MODE_COV);
    assign accept   = in_valid && (state_reg == pce_pkg::S_IDLE);
    assign can_load = !out_valid_reg || out_ready;

    // next state
    always_comb
    begin
        state_next  = state_reg;
        job_next    = job_reg;
        status_next = status_reg;
        unique case (state_reg)
            pce_pkg::S_IDLE:
            begin
                if (accept && in_last)
                begin
                    state_next = pce_pkg::S_DECIDE;
                end
            end
            pce_pkg::S_DECIDE:
            begin
                if (sts.ovf)
                begin
                    status_next = pce_pkg::ST_OVERFLOW;
                    state_next  = pce_pkg::S_OUT;
                end
                else
                begin
                    status_next = pce_pkg::ST_VALID;
                    job_next    = (mode == pce_pkg::MODE_VAR) ? pce_pkg::J_NSXX
                                                              : pce_pkg::J_NSXY;
                    state_next  = pce_pkg::S_MUL;
                end
            end
            pce_pkg::S_MUL:
            begin
                state_next = pce_pkg::S_MWAIT;
            end
            pce_pkg::S_MWAIT:
            begin
                if (sts.mul_done)
                begin
                    state_next = pce_pkg::S_MUL;
                    unique case (job_reg)
                        pce_pkg::J_NSXX: job_next = pce_pkg::J_SXSX;
                        pce_pkg::J_NSXY: job_next = pce_pkg::J_SXSY;
                        pce_pkg::J_NSYY: job_next = pce_pkg::J_SYSY;
                        pce_pkg::J_SXSX:
                            job_next = is_corr ? pce_pkg::J_NSYY : pce_pkg::J_NN;
                        pce_pkg::J_SXSY:
                            job_next = is_corr ? pce_pkg::J_NSXX : pce_pkg::J_NN;
                        pce_pkg::J_SYSY: state_next = pce_pkg::S_ZCHK;
                        pce_pkg::J_NN:   state_next = pce_pkg::S_DIV;
                        pce_pkg::J_VV:   job_next   = pce_pkg::J_CC;
                        pce_pkg::J_CC:   state_next = pce_pkg::S_SQINIT;
                        default:         state_next = pce_pkg::S_IDLE;
                    endcase
                end
            end
            pce_pkg::S_ZCHK:
            begin
                if (sts.var_zero)
                begin
                    status_next = pce_pkg::ST_ZERO_VAR;
                    state_next  = pce_pkg::S_OUT;
                end
                else
                begin
                    job_next   = pce_pkg::J_VV;
                    state_next = pce_pkg::S_MUL;
                end
            end
            pce_pkg::S_DIV:    state_next = pce_pkg::S_DWAIT;
            pce_pkg::S_DWAIT:
            begin
                if (sts.div_done)
                begin
                    state_next = pce_pkg::S_OUT;
                end
            end
            pce_pkg::S_SQINIT: state_next = pce_pkg::S_SQ;
            pce_pkg::S_SQ:
            begin
                if (sts.sq_done)
                begin
                    state_next = pce_pkg::S_OUT;
                end
            end
            pce_pkg::S_OUT:
            begin
                if (can_load)
                begin
                    state_next = pce_pkg::S_IDLE;
                end
            end
            default: state_next = pce_pkg::S_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        cmd            = '0;
        cmd.job        = job_reg;
        cmd.status     = status_reg;
        cmd.acc_en     = accept;
        out_valid_next = out_valid_reg && !out_ready;
        unique case (state_reg)
            pce_pkg::S_MUL:    cmd.mul_start = 1'b1;
            pce_pkg::S_DIV:    cmd.div_start = 1'b1;
            pce_pkg::S_SQINIT: cmd.sq_init   = 1'b1;
            pce_pkg::S_SQ:     cmd.sq_step   = 1'b1;
            pce_pkg::S_OUT:
            begin
                if (can_load)
                begin
                    cmd.out_load   = 1'b1;
                    cmd.clear      = 1'b1;
                    out_valid_next = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pce_pkg::S_IDLE;
            job_reg       <= pce_pkg::J_NSXX;
            status_reg    <= pce_pkg::ST_VALID;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            job_reg       <= job_next;
            status_reg    <= status_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == pce_pkg::S_IDLE);
    assign out_valid = out_valid_reg;
endmodule

[design/pce_dp.sv]
// Datapath: running sums, product jobs, divide, correlation root search, result register.
// Depends on pce_pkg, pce_mul and pce_div.
module pce_dp (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  pce_pkg::cmd_t                         cmd,
    input  logic [pce_pkg::MODE_W-1:0]            mode,
    input  logic signed [pce_pkg::SAMPLE_BITS-1:0] sample_x,
    input  logic signed [pce_pkg::SAMPLE_BITS-1:0] sample_y,
    output pce_pkg::sts_t                         sts,
    output logic signed [pce_pkg::RES_W-1:0]      result,
    output logic [pce_pkg::STATUS_W-1:0]          status
);
    localparam int SH_A = pce_pkg::FRAC_BITS + 2;
    localparam int SH_B = 2 * pce_pkg::FRAC_BITS + 2;
    localparam logic [pce_pkg::DD_W-1:0] POS_LIM = pce_pkg::DD_W'((64'd1 << (pce_pkg::RES_W - 1)) - 64'd1);
    localparam logic [pce_pkg::DD_W-1:0] NEG_LIM = pce_pkg::DD_W'(64'd1 << (pce_pkg::RES_W - 1));

    // running sums
    logic [pce_pkg::CNT_W-1:0]        cnt_reg;
    logic signed [pce_pkg::SUM_W-1:0] sx_reg, sy_reg;
    logic signed [pce_pkg::SQ_W-1:0]  sxx_reg, syy_reg;
    logic signed [pce_pkg::XY_W-1:0]  sxy_reg;
    logic                             ovf_reg;
    logic signed [2*pce_pkg::SAMPLE_BITS-1:0] pxx, pyy, pxy;
    logic                             full;

    assign pxx  = sample_x * sample_x;
    assign pyy  = sample_y * sample_y;
    assign pxy  = sample_x * sample_y;
    assign full = ({1'b0, cnt_reg} >= (pce_pkg::CNT_W + 1)'(pce_pkg::MAX_SAMPLES));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            sx_reg  <= '0;
            sy_reg  <= '0;
            sxx_reg <= '0;
            syy_reg <= '0;
            sxy_reg <= '0;
            ovf_reg <= 1'b0;
        end
        else if (cmd.clear)
        begin
            cnt_reg <= '0;
            sx_reg  <= '0;
            sy_reg  <= '0;
            sxx_reg <= '0;
            syy_reg <= '0;
            sxy_reg <= '0;
            ovf_reg <= 1'b0;
        end
        else if (cmd.acc_en)
        begin
            if (full)
            begin
                ovf_reg <= 1'b1;
            end
            else
            begin
                cnt_reg <= cnt_reg + 1'b1;
                sx_reg  <= sx_reg + pce_pkg::SUM_W'(sample_x);
                sy_reg  <= sy_reg + pce_pkg::SUM_W'(sample_y);
                sxx_reg <= sxx_reg + pce_pkg::SQ_W'(pxx);
                syy_reg <= syy_reg + pce_pkg::SQ_W'(pyy);
                sxy_reg <= sxy_reg + pce_pkg::XY_W'(pxy);
            end
        end
    end

    // operand selection for the shared multiplier
    logic [pce_pkg::SUM_W-1:0]        sx_mag, sy_mag;
    logic [pce_pkg::XY_W-1:0]         sxy_mag;
    logic signed [pce_pkg::CEN_W-1:0] first_reg, vx_reg, vy_reg, c_reg;
    logic [pce_pkg::CEN_W-1:0]        c_mag;
    logic [pce_pkg::NN_W-1:0]         nn_reg;
    logic [pce_pkg::PRD_W-1:0]        p_reg, t_reg;
    logic [pce_pkg::MUL_W-1:0]        mul_a, mul_b, n_ext;
    logic                             mul_neg, mul_neg_reg;
    logic                             mul_done;
    logic [pce_pkg::PRD_W-1:0]        prod;
    logic signed [pce_pkg::PRD_W:0]   prod_s;

    assign sx_mag  = sx_reg[pce_pkg::SUM_W-1] ? pce_pkg::SUM_W'(-sx_reg) : sx_reg;
    assign sy_mag  = sy_reg[pce_pkg::SUM_W-1] ? pce_pkg::SUM_W'(-sy_reg) : sy_reg;
    assign sxy_mag = sxy_reg[pce_pkg::XY_W-1] ? pce_pkg::XY_W'(-sxy_reg) : sxy_reg;
    assign c_mag   = c_reg[pce_pkg::CEN_W-1] ? pce_pkg::CEN_W'(-c_reg) : c_reg;
    assign n_ext   = pce_pkg::MUL_W'(cnt_reg);

    always_comb
    begin
        mul_a   = n_ext;
        mul_b   = n_ext;
        mul_neg = 1'b0;
        case (cmd.job)
            pce_pkg::J_NSXX: mul_b = pce_pkg::MUL_W'(sxx_reg);
            pce_pkg::J_NSYY: mul_b = pce_pkg::MUL_W'(syy_reg);
            pce_pkg::J_NSXY:
            begin
                mul_b   = pce_pkg::MUL_W'(sxy_mag);
                mul_neg = sxy_reg[pce_pkg::XY_W-1];
            end
            pce_pkg::J_SXSX:
            begin
                mul_a = pce_pkg::MUL_W'(sx_mag);
                mul_b = pce_pkg::MUL_W'(sx_mag);
            end
            pce_pkg::J_SYSY:
            begin
                mul_a = pce_pkg::MUL_W'(sy_mag);
                mul_b = pce_pkg::MUL_W'(sy_mag);
            end
            pce_pkg::J_SXSY:
            begin
                mul_a   = pce_pkg::MUL_W'(sx_mag);
                mul_b   = pce_pkg::MUL_W'(sy_mag);
                mul_neg = sx_reg[pce_pkg::SUM_W-1] ^ sy_reg[pce_pkg::SUM_W-1];
            end
            pce_pkg::J_VV:
            begin
                mul_a = pce_pkg::MUL_W'(vx_reg);
                mul_b = pce_pkg::MUL_W'(vy_reg);
            end
            pce_pkg::J_CC:
            begin
                mul_a = pce_pkg::MUL_W'(c_mag);
                mul_b = pce_pkg::MUL_W'(c_mag);
            end
            default: ;
        endcase
    end

    pce_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cmd.mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .done    (mul_done),
        .product (prod)
    );

    assign prod_s = mul_neg_reg ? -$signed({1'b0, prod}) : $signed({1'b0, prod});

    // store each product where its job says
    always_ff @(posedge clk)
    begin
        if (cmd.mul_start)
        begin
            mul_neg_reg <= mul_neg;
        end
        if (mul_done)
        begin
            case (cmd.job) inside
                pce_pkg::J_NSXX, pce_pkg::J_NSXY, pce_pkg::J_NSYY:
                    first_reg <= prod_s[pce_pkg::CEN_W-1:0];
                pce_pkg::J_SXSX: vx_reg <= first_reg - prod_s[pce_pkg::CEN_W-1:0];
                pce_pkg::J_SXSY: c_reg  <= first_reg - prod_s[pce_pkg::CEN_W-1:0];
                pce_pkg::J_SYSY: vy_reg <= first_reg - prod_s[pce_pkg::CEN_W-1:0];
                pce_pkg::J_NN:   nn_reg <= prod[pce_pkg::NN_W-1:0];
                pce_pkg::J_VV:   p_reg  <= prod;
                pce_pkg::J_CC:   t_reg  <= prod;
                default: ;
            endcase
        end
    end

    // variance and covariance: round(num * 2^FRAC / n^2), half away from zero
    logic signed [pce_pkg::CEN_W-1:0] num;
    logic [pce_pkg::CEN_W-1:0]        num_mag;
    logic                             num_neg_reg;
    logic [pce_pkg::DD_W-1:0]         dividend;
    logic [pce_pkg::DS_W-1:0]         divisor;
    logic                             div_done;
    logic [pce_pkg::DD_W-1:0]         quot, quot_sat;

    assign num      = (mode == pce_pkg::MODE_VAR) ? vx_reg : c_reg;
    assign num_mag  = num[pce_pkg::CEN_W-1] ? pce_pkg::CEN_W'(-num) : num;
    assign dividend = (pce_pkg::DD_W'(num_mag) << (pce_pkg::FRAC_BITS + 1))
                    + pce_pkg::DD_W'(nn_reg);
    assign divisor  = {nn_reg, 1'b0};

    pce_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (dividend),
        .divisor  (divisor),
        .done     (div_done),
        .quotient (quot)
    );

    always_comb
    begin
        quot_sat = quot;
        if (num_neg_reg && (quot > NEG_LIM))
        begin
            quot_sat = NEG_LIM;
        end
        else if (!num_neg_reg && (quot > POS_LIM))
        begin
            quot_sat = POS_LIM;
        end
    end

    // correlation: largest m with (2m-1)^2 * P <= C^2 * 2^(2*FRAC+2), one bit a step
    logic signed [pce_pkg::E_W-1:0] e_reg, a_reg, b_reg;
    logic signed [pce_pkg::E_W-1:0] e_try, a_acc;
    logic [pce_pkg::SQ_STEPS-2:0]   m_reg;
    logic [pce_pkg::SQC_W-1:0]      sq_cnt_reg;
    logic                           take;

    assign e_try = e_reg - a_reg - b_reg;
    assign take  = !e_try[pce_pkg::E_W-1];
    assign a_acc = take ? a_reg + (b_reg <<< 1) : a_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.sq_init)
        begin
            e_reg      <= (pce_pkg::E_W'(t_reg) <<< SH_B) - pce_pkg::E_W'(p_reg);
            a_reg      <= -(pce_pkg::E_W'(p_reg) <<< SH_A);
            b_reg      <= pce_pkg::E_W'(p_reg) <<< SH_B;
            m_reg      <= '0;
            sq_cnt_reg <= pce_pkg::SQC_W'(pce_pkg::SQ_STEPS);
        end
        else if (cmd.sq_step)
        begin
            if (take)
            begin
                e_reg <= e_try;
            end
            a_reg      <= a_acc >>> 1;
            b_reg      <= b_reg >>> 2;
            m_reg      <= {m_reg[pce_pkg::SQ_STEPS-3:0], take};
            sq_cnt_reg <= sq_cnt_reg - 1'b1;
        end
    end

    // result staging and output word
    logic signed [pce_pkg::RES_W-1:0]   res_reg, out_res_reg;
    logic [pce_pkg::STATUS_W-1:0]       out_st_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
        begin
            num_neg_reg <= num[pce_pkg::CEN_W-1];
        end
        if (div_done)
        begin
            res_reg <= num_neg_reg ? -pce_pkg::RES_W'(quot_sat) : pce_pkg::RES_W'(quot_sat);
        end
        else if (cmd.sq_step && (sq_cnt_reg == pce_pkg::SQC_W'(1)))
        begin
            res_reg <= c_reg[pce_pkg::CEN_W-1]
                     ? -pce_pkg::RES_W'({m_reg, take})
                     : pce_pkg::RES_W'({m_reg, take});
        end
        if (cmd.out_load)
        begin
            out_res_reg <= (cmd.status == pce_pkg::ST_VALID) ? res_reg : '0;
            out_st_reg  <= cmd.status;
        end
    end

    assign sts.ovf      = ovf_reg;
    assign sts.mul_done = mul_done;
    assign sts.div_done = div_done;
    assign sts.var_zero = (vx_reg == '0) || (vy_reg == '0);
    assign sts.sq_done  = cmd.sq_step && (sq_cnt_reg == pce_pkg::SQC_W'(1));
    assign result       = out_res_reg;
    assign status       = out_st_reg;
endmodule

[design/pearson_correlation_engine.sv]
// Top level of the correlation engine: mode register, controller and datapath.
// Depends on pce_pkg, pce_if, pce_ctrl and pce_dp.
//
// Streams paired signed samples (sample_x, sample_y) and keeps a count and the
// running sums of x, y, x*x, y*y and x*y; the word marked last closes the set
// and yields one result word. Mode 0 gives the population variance of x, mode 1
// the population covariance, modes 2 and 3 the Pearson correlation, all with 16
// fraction bits, rounded half away from zero from the exact integer sums. Status
// 1 flags a zero variance in correlation, status 2 a set longer than
// MAX_SAMPLES pairs (both with result 0). Sums clear after each result.
// Rate: one sample word per cycle while accumulating. After the last word the
// block stalls on a shared shift-add multiplier of 59 bits and then either a
// 77-step restoring divide (variance, covariance) or, for correlation, eight
// products and a 17-step root search, cut short when a variance is zero.
// A set that was too long goes from the decide state straight to the output
// state. The result sits in an output register, so the next set may start
// streaming while it waits to be taken. Write mode only while idle.
module pearson_correlation_engine (
    input  logic                         clk,
    input  logic                         rst_n,
    pce_in_if.sink                       samples,
    pce_out_if.source                    results,
    input  logic                         cfg_we,
    input  logic [pce_pkg::MODE_W-1:0]   cfg_wdata
);
    logic [pce_pkg::MODE_W-1:0] mode_reg;
    pce_pkg::cmd_t              cmd;
    pce_pkg::sts_t              sts;

    // hold the statistic selector
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= pce_pkg::MODE_VAR;
        end
        else if (cfg_we)
        begin
            mode_reg <= cfg_wdata;
        end
    end

    // sequence: accumulate, then products, divide or root search, then output
    pce_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .mode      (mode_reg),
        .in_valid  (samples.valid),
        .in_last   (samples.last),
        .in_ready  (samples.ready),
        .out_valid (results.valid),
        .out_ready (results.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // sums and arithmetic
    pce_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .mode     (mode_reg),
        .sample_x (samples.sample_x),
        .sample_y (samples.sample_y),
        .sts      (sts),
        .result   (results.result),
        .status   (results.status)
    );
endmodule
